@@ sv/bffa_pkg.sv @@
package bffa_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_NUM_BLOCKS  = 256;
  localparam int DEF_BLOCK_BYTES = 8;

  // Fixed field widths
  localparam int SIZE_W    = 16;
  localparam int ADDR_W    = 16;
  localparam int BYTE_BITS = 8;

  // Quotient width: a size plus rounding fits in 17 bits
  localparam int DIV_W = SIZE_W + 1;

  // Request codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Configuration port
  localparam int   APB_ADDR_W     = 3;
  localparam int   APB_DATA_W     = 32;
  localparam logic REG_HEAP_BASE  = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SIZE,
    ST_OFFS,
    ST_SCAN,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_DONE
  } state_t;

endpackage

@@ sv/bffa_req_if.sv @@
interface bffa_req_if import bffa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [SIZE_W-1:0] req_size;
  logic [ADDR_W-1:0] free_addr;

  modport source (output valid, req_type, req_size, free_addr, input ready);
  modport sink (input valid, req_type, req_size, free_addr, output ready);
endinterface

@@ sv/bffa_rsp_if.sv @@
interface bffa_rsp_if import bffa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] result_addr;
  logic              success;

  modport source (output valid, result_addr, success, input ready);
  modport sink (input valid, result_addr, success, output ready);
endinterface

@@ sv/bffa_map.sv @@
module bffa_map import bffa_pkg::*; #(
  parameter int DEPTH  = 32,
  parameter int BYTE_W = 5
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [BYTE_W-1:0]    wr_addr,
  input  logic [BYTE_BITS-1:0] wr_data,
  input  logic [BYTE_W-1:0]    rd_addr,
  output logic [BYTE_BITS-1:0] rd_data
);

  logic [BYTE_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/bffa_recip_div.sv @@
module bffa_recip_div import bffa_pkg::*; #(
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
  input  logic             clk,
  input  logic [DIV_W-1:0] dividend,
  output logic [DIV_W-1:0] quotient
);

  // floor(x / d) == (x * ceil(2^(N+L) / d)) >> (N+L) for every x below 2^N
  localparam int              L     = $clog2(BLOCK_BYTES);
  localparam int              SHIFT = DIV_W + L;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
  localparam int              M_W   = DIV_W + 1;
  localparam int              P_W   = DIV_W + M_W;

  logic [M_W-1:0] recip;
  logic [P_W-1:0] prod;

  assign recip = M_W'(RECIP);
  assign prod  = P_W'(dividend) * P_W'(recip);

  always_ff @(posedge clk) begin
    quotient <= DIV_W'(prod >> SHIFT);
  end

endmodule

@@ sv/bffa_byte_unit.sv @@
module bffa_byte_unit import bffa_pkg::*; #(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
  parameter int BYTE_W     = 5,
  parameter int IDX_W      = 9
) (
  input  logic [BYTE_BITS-1:0] map_byte,
  input  logic [BYTE_W-1:0]    byte_sel,
  input  logic [IDX_W-1:0]     run_in,
  input  logic [IDX_W-1:0]     need,
  input  logic [IDX_W-1:0]     lo,
  input  logic [IDX_W-1:0]     hi,
  output logic                 found,
  output logic [IDX_W-1:0]     start,
  output logic [IDX_W-1:0]     run_out,
  output logic [BYTE_BITS-1:0] mask
);

  localparam logic [IDX_W-1:0] NB = IDX_W'(NUM_BLOCKS);

  logic [IDX_W-1:0] run;
  logic [IDX_W-1:0] idx;

  // Walk the eight bits in order: count free blocks, stop at the first fit
  always_comb begin
    run   = run_in;
    found = 1'b0;
    start = '0;
    mask  = '0;
    idx   = '0;
    for (int j = 0; j < BYTE_BITS; j++) begin
      idx = IDX_W'({byte_sel, 3'(j)});
      if (idx < NB && !found) begin
        if (map_byte[j]) begin
          run = '0;
        end else begin
          run = run + 1'b1;
          if (run >= need) begin
            found = 1'b1;
            start = idx + IDX_W'(1) - need;
          end
        end
      end
      mask[j] = (idx >= lo) && (idx < hi);
    end
    run_out = run;
  end

endmodule

@@ sv/bitmap_first_fit_allocator.sv @@
// First-fit bitmap block allocator. The heap holds NUM_BLOCKS blocks of
// BLOCK_BYTES bytes, tracked by a used/free bitmap kept in an internal memory
// of (NUM_BLOCKS+7)/8 bytes. An allocate item rounds req_size up to whole
// blocks, takes the lowest run of that many free blocks, marks it used and
// returns heap_base + index*BLOCK_BYTES (16-bit wrap); a zero size, a size
// over the heap or no free run returns success 0 and address 0. A free item
// clears the run starting at the block that holds free_addr (offset from
// heap_base, 16-bit wrap), clipped at the heap end, and returns success 1.
// After reset the block clears the bitmap before it raises ready; configuration
// writes are taken during that time. One item is worked on at a time. The
// bitmap memory port sets the timing: an allocate passes a size step, then
// scans bitmap bytes from byte 0 up to the one that closes the run (all bytes
// when no run fits; a zero or oversized size skips the scan), then reads and
// writes back each byte marked; a free passes a size step and an offset step,
// then reads and writes back each byte touched. With the defaults the bitmap
// holds 32 bytes. The result sits in an output register, so ready returns
// while it still waits to be taken.
module bitmap_first_fit_allocator import bffa_pkg::*; #(
  parameter int NUM_BLOCKS  = DEF_NUM_BLOCKS,
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
  input  logic                  clk,
  input  logic                  rst,
  bffa_req_if.sink              req,
  bffa_rsp_if.source            rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int MAP_BYTES = (NUM_BLOCKS + 7) / 8;
  localparam int BYTE_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int IDX_W     = $clog2(MAP_BYTES * 8 + 1);
  localparam logic [BYTE_W-1:0] LAST_BYTE = BYTE_W'(MAP_BYTES - 1);
  localparam logic [IDX_W-1:0]  NB_IDX    = IDX_W'(NUM_BLOCKS);
  localparam logic [DIV_W-1:0]  NB_DIV    = DIV_W'(NUM_BLOCKS);

  // Configuration register
  logic [ADDR_W-1:0] heap_base;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == REG_HEAP_BASE);

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= '0;
    end else if (cfg_wr) begin
      heap_base <= pwdata[ADDR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[APB_ADDR_W-1:2] == REG_HEAP_BASE) begin
      prdata = APB_DATA_W'(heap_base);
    end
  end

  // Sequencer and work registers
  state_t            state, state_next;
  logic [BYTE_W-1:0] clr_idx;
  logic              op_free;
  logic [ADDR_W-1:0] free_addr_q;
  logic [DIV_W-1:0]  n_blocks;
  logic [IDX_W-1:0]  run;
  logic [BYTE_W-1:0] scan_byte;
  logic [IDX_W-1:0]  lo, hi;
  logic [BYTE_W-1:0] cur_byte, last_byte;
  logic              ok;

  // Output register
  logic              out_valid;
  logic [ADDR_W-1:0] out_addr;
  logic              out_success;

  // Datapath wires
  logic [DIV_W-1:0]     div_in, div_q;
  logic [BYTE_BITS-1:0] rd_data, wr_data, mask;
  logic [BYTE_W-1:0]    rd_addr, wr_addr;
  logic                 wr_en;
  logic                 found;
  logic [IDX_W-1:0]     fit_start, run_out;
  logic [IDX_W-1:0]     lo_c, hi_c, hi_m1;
  logic [DIV_W:0]       end_sum;
  logic                 accept, out_free, size_bad, offs_none;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  assign rsp.valid       = out_valid;
  assign rsp.result_addr = out_addr;
  assign rsp.success     = out_success;

  assign size_bad  = (div_q == '0) || (div_q > NB_DIV);
  assign offs_none = (n_blocks == '0) || (div_q >= NB_DIV);
  assign end_sum   = (DIV_W + 1)'(div_q) + (DIV_W + 1)'(n_blocks);

  bffa_recip_div #(.BLOCK_BYTES(BLOCK_BYTES)) u_div (
    .clk      (clk),
    .dividend (div_in),
    .quotient (div_q)
  );

  bffa_map #(.DEPTH(MAP_BYTES), .BYTE_W(BYTE_W)) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bffa_byte_unit #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .BYTE_W     (BYTE_W),
    .IDX_W      (IDX_W)
  ) u_byte (
    .map_byte (rd_data),
    .byte_sel ((state == ST_SCAN) ? scan_byte : cur_byte),
    .run_in   (run),
    .need     (n_blocks[IDX_W-1:0]),
    .lo       (lo),
    .hi       (hi),
    .found    (found),
    .start    (fit_start),
    .run_out  (run_out),
    .mask     (mask)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_idx == LAST_BYTE) state_next = ST_IDLE;
      ST_IDLE:   if (accept) state_next = ST_SIZE;
      ST_SIZE: begin
        if (op_free) begin
          state_next = ST_OFFS;
        end else if (size_bad) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_OFFS:   state_next = offs_none ? ST_DONE : ST_RMW_RD;
      ST_SCAN: begin
        if (found) begin
          state_next = ST_RMW_RD;
        end else if (scan_byte == LAST_BYTE) begin
          state_next = ST_DONE;
        end
      end
      ST_RMW_RD: state_next = ST_RMW_WR;
      ST_RMW_WR: state_next = (cur_byte == last_byte) ? ST_DONE : ST_RMW_RD;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    div_in  = DIV_W'(req.req_size) + DIV_W'(BLOCK_BYTES - 1);
    rd_addr = cur_byte;
    wr_en   = 1'b0;
    wr_addr = cur_byte;
    wr_data = op_free ? (rd_data & ~mask) : (rd_data | mask);
    lo_c    = fit_start;
    hi_c    = fit_start + n_blocks[IDX_W-1:0];
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
        wr_data = '0;
      end
      ST_SIZE: begin
        div_in  = DIV_W'(16'(free_addr_q - heap_base));
        rd_addr = '0;
      end
      ST_OFFS: begin
        lo_c = div_q[IDX_W-1:0];
        hi_c = (end_sum > (DIV_W + 1)'(NUM_BLOCKS)) ? NB_IDX : end_sum[IDX_W-1:0];
      end
      ST_SCAN: begin
        rd_addr = (scan_byte == LAST_BYTE) ? scan_byte : scan_byte + 1'b1;
      end
      ST_RMW_WR: wr_en = 1'b1;
      default: ;
    endcase
    hi_m1 = hi_c - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  // Work registers: payload, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        op_free     <= req.req_type;
        free_addr_q <= req.free_addr;
      end
      ST_SIZE: begin
        n_blocks  <= div_q;
        ok        <= op_free;
        run       <= '0;
        scan_byte <= '0;
      end
      ST_OFFS, ST_SCAN: begin
        // Latch the run to mark; a failed or empty request keeps ok as is
        run       <= run_out;
        scan_byte <= scan_byte + 1'b1;
        if (state == ST_OFFS || found) begin
          lo        <= lo_c;
          hi        <= hi_c;
          cur_byte  <= BYTE_W'(lo_c >> 3);
          last_byte <= BYTE_W'(hi_m1 >> 3);
          ok        <= 1'b1;
        end
      end
      ST_RMW_WR: cur_byte <= cur_byte + 1'b1;
      default: ;
    endcase
  end

  // Output register: hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_success <= ok;
      out_addr    <= (ok && !op_free) ? heap_base + ADDR_W'(lo * BLOCK_BYTES) : '0;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_SIZE)
    else $error("accepted item did not start the size step");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_DONE || state == ST_SCAN) |-> !wr_en)
    else $error("bitmap written outside clear or marking");

  a_range_ok: assert property (@(posedge clk) disable iff (rst)
    state == ST_RMW_RD |-> (lo < hi) && (hi <= NB_IDX) && (cur_byte <= last_byte))
    else $error("marking range out of bounds");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_success) |-> out_addr == '0)
    else $error("failed allocation carries a nonzero address");

  a_busy_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !out_free) |=> state == ST_DONE)
    else $error("result dropped while output register is full");

endmodule

@@ tb/sv/tb_bitmap_first_fit_allocator.sv @@
module tb_bitmap_first_fit_allocator;
  import bffa_pkg::*;

  localparam int NB          = DEF_NUM_BLOCKS;
  localparam int BB          = DEF_BLOCK_BYTES;
  localparam int LIMIT       = 500_000;  // cycles, several times the slowest legal run
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 170;
  localparam int IDLE_PCT    = 11;
  localparam int SETTLE      = 12;       // quiet cycles after the last result

  // A directed row is either one request item or a new heap base;
  // for a base row the value rides in the addr field.
  typedef enum logic {ROW_REQ, ROW_BASE} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic              typ;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    logic              typed;     // expected result below is taken as is
    logic [ADDR_W-1:0] exp_addr;
    logic              exp_ok;
  } row_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              ok;
  } grant_t;

  // Allocation still held, used to build well-formed releases
  typedef struct packed {
    logic [15:0]       first_blk;
    logic [SIZE_W-1:0] bytes;
  } run_t;

  localparam int NROWS = 27;
  localparam row_t PLAN [NROWS] = '{
    // zero size, far too large, one block over the heap: all refused
    '{ROW_REQ,  REQ_ALLOC, 16'd0,     16'h0000, 1'b1, 16'h0000, 1'b0},
    '{ROW_REQ,  REQ_ALLOC, 16'hFFFF,  16'h0000, 1'b1, 16'h0000, 1'b0},
    '{ROW_REQ,  REQ_ALLOC, 16'd2049,  16'h0000, 1'b1, 16'h0000, 1'b0},
    // fresh heap: runs stack up from block 0
    '{ROW_REQ,  REQ_ALLOC, 16'd1,     16'h0000, 1'b1, 16'h0000, 1'b1},
    '{ROW_REQ,  REQ_ALLOC, 16'd8,     16'h0000, 1'b1, 16'h0008, 1'b1},
    '{ROW_REQ,  REQ_ALLOC, 16'd9,     16'h0000, 1'b1, 16'h0010, 1'b1},
    // open a hole at block 1 and refill it
    '{ROW_REQ,  REQ_FREE,  16'd8,     16'h0008, 1'b1, 16'h0000, 1'b1},
    '{ROW_REQ,  REQ_ALLOC, 16'd3,     16'h0000, 1'b0, 16'h0000, 1'b0},
    // zero-size release, release past the heap, release of free blocks
    '{ROW_REQ,  REQ_FREE,  16'd0,     16'h0000, 1'b1, 16'h0000, 1'b1},
    '{ROW_REQ,  REQ_FREE,  16'hFFFF,  16'hFFFF, 1'b1, 16'h0000, 1'b1},
    '{ROW_REQ,  REQ_FREE,  16'd16,    16'd1000, 1'b1, 16'h0000, 1'b1},
    // unaligned release address rounds down to its block
    '{ROW_REQ,  REQ_FREE,  16'd1,     16'd17,   1'b1, 16'h0000, 1'b1},
    '{ROW_REQ,  REQ_ALLOC, 16'd8,     16'h0000, 1'b0, 16'h0000, 1'b0},
    // whole heap: refused while busy, granted once cleared, then full
    '{ROW_REQ,  REQ_ALLOC, 16'd2048,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_REQ,  REQ_FREE,  16'd2048,  16'h0000, 1'b1, 16'h0000, 1'b1},
    '{ROW_REQ,  REQ_ALLOC, 16'd2048,  16'h0000, 1'b1, 16'h0000, 1'b1},
    '{ROW_REQ,  REQ_ALLOC, 16'd1,     16'h0000, 1'b1, 16'h0000, 1'b0},
    '{ROW_REQ,  REQ_FREE,  16'hFFFF,  16'h0000, 1'b1, 16'h0000, 1'b1},
    // base near the top: addresses wrap, releases below base wrap too
    '{ROW_BASE, REQ_ALLOC, 16'd0,     16'hFFF8, 1'b0, 16'h0000, 1'b0},
    '{ROW_REQ,  REQ_ALLOC, 16'd16,    16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_REQ,  REQ_FREE,  16'd8,     16'h0000, 1'b1, 16'h0000, 1'b1},
    '{ROW_REQ,  REQ_ALLOC, 16'd8,     16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_REQ,  REQ_FREE,  16'd2048,  16'h1000, 1'b1, 16'h0000, 1'b1},
    '{ROW_REQ,  REQ_FREE,  16'hFFFF,  16'hFFF8, 1'b1, 16'h0000, 1'b1},
    '{ROW_BASE, REQ_ALLOC, 16'd0,     16'hFFFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_REQ,  REQ_ALLOC, 16'd7,     16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_REQ,  REQ_ALLOC, 16'd24,    16'h0000, 1'b0, 16'h0000, 1'b0}
  };

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  bffa_req_if req_if ();
  bffa_rsp_if rsp_if ();

  bitmap_first_fit_allocator dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_if),
    .rsp     (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow state of the allocator
  logic [NB-1:0]     blk_busy;
  logic [ADDR_W-1:0] base_reg;
  run_t              live_runs[$];
  grant_t            awaited_grants[$];

  logic no_idle;
  int   mismatches;
  int   n_granted, n_refused, n_released, n_bases;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // Work out the result of one request and advance the shadow bitmap.
  function automatic grant_t allocate_or_release(input logic typ,
                                                 input logic [SIZE_W-1:0] size,
                                                 input logic [ADDR_W-1:0] addr);
    grant_t      g;
    int unsigned nblk;
    int unsigned run;
    int unsigned start;
    int unsigned first;
    logic [15:0] offs;
    bit          found;
    g     = '0;
    nblk  = (int'(size) + BB - 1) / BB;
    run   = 0;
    start = 0;
    found = 1'b0;
    if (typ == REQ_ALLOC) begin
      if (nblk != 0 && nblk <= NB) begin
        for (int i = 0; i < NB && !found; i++) begin
          if (blk_busy[i]) begin
            run = 0;
          end else begin
            run++;
            if (run >= nblk) begin
              start = i + 1 - nblk;
              found = 1'b1;
            end
          end
        end
      end
      if (found) begin
        for (int i = 0; i < nblk; i++) blk_busy[start + i] = 1'b1;
        g.addr = ADDR_W'(base_reg + start * BB);
        g.ok   = 1'b1;
        live_runs.push_back('{first_blk: 16'(start), bytes: size});
        n_granted++;
      end else begin
        n_refused++;
      end
    end else begin
      offs  = addr - base_reg;
      first = offs / BB;
      // clip at the heap end; nothing past it is touched
      for (int i = 0; i < nblk && first + i < NB; i++) blk_busy[first + i] = 1'b0;
      g.ok = 1'b1;
      n_released++;
    end
    return g;
  endfunction

  // Receiver: hold ready low about one cycle in nine, never in the steady phase
  always @(negedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Compare each taken result with the oldest awaited one
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (awaited_grants.size() == 0) begin
        $error("result with no request outstanding: result_addr %h success %b",
               rsp_if.result_addr, rsp_if.success);
        mismatches++;
      end else begin
        grant_t g;
        g = awaited_grants.pop_front();
        if (rsp_if.result_addr !== g.addr) begin
          $error("result_addr: expected %h, got %h", g.addr, rsp_if.result_addr);
          mismatches++;
        end
        if (rsp_if.success !== g.ok) begin
          $error("success: expected %b, got %b", g.ok, rsp_if.success);
          mismatches++;
        end
      end
    end
  end

  // One APB transfer: setup on the next falling edge, access on the one after,
  // done at the rising edge with pready, bus released on the following fall.
  task automatic apb_transfer(input logic wr, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_ADDR_W'({REG_HEAP_BASE, 2'b00});
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write the heap base, mirror it, and read it back
  task automatic set_heap_base(input logic [APB_DATA_W-1:0] wdata);
    logic [APB_DATA_W-1:0] rd;
    apb_transfer(1'b1, wdata, rd);
    base_reg = wdata[ADDR_W-1:0];
    n_bases++;
    apb_transfer(1'b0, '0, rd);
    if (rd[ADDR_W-1:0] !== base_reg) begin
      $error("heap_base: expected %h, got %h", base_reg, rd[ADDR_W-1:0]);
      mismatches++;
    end
  endtask

  // Drop valid and hold until every awaited result is in; called on a falling edge
  task automatic drain_results(input int settle);
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (awaited_grants.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
    @(negedge clk);
  endtask

  // Present one item from a falling edge; on return valid is still high and
  // we are on the falling edge after acceptance.
  task automatic send_item(input logic typ, input logic [SIZE_W-1:0] size,
                           input logic [ADDR_W-1:0] addr,
                           input logic typed, input grant_t typed_grant);
    grant_t g;
    if (!no_idle) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        req_if.valid <= 1'b0;
        @(negedge clk);
      end
    end
    req_if.valid     <= 1'b1;
    req_if.req_type  <= typ;
    req_if.req_size  <= size;
    req_if.free_addr <= addr;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    g = allocate_or_release(typ, size, addr);
    awaited_grants.push_back(typed ? typed_grant : g);
    @(negedge clk);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return SIZE_W'($urandom_range(1, 64));
    if (r < 80) return SIZE_W'($urandom_range(65, 512));
    if (r < 90) return SIZE_W'($urandom_range(513, NB * BB));
    if (r < 94) return '0;
    return SIZE_W'($urandom);
  endfunction

  // Mostly allocations and releases of live runs; the rest is random releases
  task automatic random_item(output logic typ, output logic [SIZE_W-1:0] size,
                             output logic [ADDR_W-1:0] addr);
    int unsigned r;
    int unsigned k;
    run_t        lr;
    r    = $urandom_range(0, 99);
    typ  = REQ_ALLOC;
    size = pick_size();
    addr = ADDR_W'($urandom);
    if (r >= 55) begin
      typ = REQ_FREE;
      if (r < 88 && live_runs.size() != 0) begin
        k = $urandom_range(0, live_runs.size() - 1);
        lr = live_runs[k];
        live_runs.delete(k);
        size = lr.bytes;
        // point anywhere inside the first block of the run
        addr = ADDR_W'(base_reg + lr.first_blk * BB + $urandom_range(0, BB - 1));
      end
    end
  endtask

  initial begin
    logic                  typ;
    logic [SIZE_W-1:0]     size;
    logic [ADDR_W-1:0]     addr;
    logic [APB_DATA_W-1:0] wdata;
    grant_t                tg;

    // Every input known from time zero
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_if.valid     = 1'b0;
    req_if.req_type  = REQ_ALLOC;
    req_if.req_size  = '0;
    req_if.free_addr = '0;
    rsp_if.ready     = 1'b0;
    no_idle          = 1'b0;
    blk_busy         = '0;
    base_reg         = '0;
    mismatches       = 0;
    n_granted        = 0;
    n_refused        = 0;
    n_released       = 0;
    n_bases          = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Base goes to zero explicitly while the bitmap is still being cleared
    set_heap_base('0);

    // Directed walk through the table
    for (int r = 0; r < NROWS; r++) begin
      if (PLAN[r].kind == ROW_BASE) begin
        drain_results(SETTLE);
        set_heap_base({16'h0, PLAN[r].addr});
      end else begin
        tg = '{addr: PLAN[r].exp_addr, ok: PLAN[r].exp_ok};
        send_item(PLAN[r].typ, PLAN[r].size, PLAN[r].addr, PLAN[r].typed, tg);
      end
    end

    // Random phases, each under its own heap base; the third runs with no idling
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results(SETTLE);
      case (ph)
        0:       wdata = {16'($urandom), 16'h0000};
        1:       wdata = {16'($urandom), 16'hFFFF};
        default: wdata = $urandom;
      endcase
      set_heap_base(wdata);
      no_idle <= (ph == 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // hold off the sender until the block has answered everything
        if (ph == 3 && k == PHASE_ITEMS / 2) drain_results(0);
        random_item(typ, size, addr);
        send_item(typ, size, addr, 1'b0, '0);
      end
    end

    drain_results(SETTLE * 4);

    $display("Ran %0d requests: %0d allocations granted, %0d refused, %0d releases",
             n_granted + n_refused + n_released, n_granted, n_refused, n_released);
    $display("Heap base written %0d times, including both ends of its range", n_bases);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
